[rtl/core/acpu_io_pkg.sv]
// Package: payload structs and register map constants for the audio coprocessor I/O unit.
package acpu_io_pkg;

    // Item kinds
    localparam logic [2:0] FUNC_TICK     = 3'd0;
    localparam logic [2:0] FUNC_COPRO_RD = 3'd1;
    localparam logic [2:0] FUNC_COPRO_WR = 3'd2;
    localparam logic [2:0] FUNC_CPU_RD   = 3'd3;
    localparam logic [2:0] FUNC_CPU_WR   = 3'd4;

    // Read data source codes
    localparam logic [1:0] SRC_BLOCK = 2'd0;
    localparam logic [1:0] SRC_ROM   = 2'd1;
    localparam logic [1:0] SRC_RAM   = 2'd2;

    // Address decode
    localparam logic [15:0] REG_PAGE_MASK = 16'hFFF0;
    localparam logic [15:0] REG_PAGE      = 16'h00F0;
    localparam logic [15:0] ROM_MASK      = 16'hFFC0;

    // Coprocessor register offsets within the I/O page
    localparam logic [3:0] REG_CONTROL = 4'h1;
    localparam logic [3:0] REG_PORT0   = 4'h4;
    localparam logic [3:0] REG_PORT1   = 4'h5;
    localparam logic [3:0] REG_PORT2   = 4'h6;
    localparam logic [3:0] REG_PORT3   = 4'h7;
    localparam logic [3:0] REG_AUX0    = 4'h8;
    localparam logic [3:0] REG_AUX1    = 4'h9;
    localparam logic [3:0] REG_DIV0    = 4'hA;
    localparam logic [3:0] REG_DIV1    = 4'hB;
    localparam logic [3:0] REG_DIV2    = 4'hC;
    localparam logic [3:0] REG_CNT0    = 4'hD;
    localparam logic [3:0] REG_CNT1    = 4'hE;
    localparam logic [3:0] REG_CNT2    = 4'hF;

    // Control register bit that selects the boot ROM
    localparam int CTRL_ROM_BIT = 7;

    // Divider value written as zero
    localparam logic [8:0] DIV_FULL = 9'd256;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] addr;
        logic [1:0]  port;
        logic [7:0]  wdata;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic [1:0] source;
        logic       ram_store;
    } result_t;

endpackage

[rtl/core/audio_cpu_io_ports_and_timers_unit.sv]
// Top level: mailbox ports, auxiliary bytes, control register and three timers.
// A result is registered in the output register, or in the skid entry while the output is held.
// Throughput: one item per cycle while item_stall is low; a two-entry output stage
// (result plus skid) keeps input transfers going while one result waits.
// Reset: asynchronous; timers disabled with divider 1, all ports and counts
// zero, boot ROM selected, output stage empty.
module audio_cpu_io_ports_and_timers_unit #(
    parameter int SLOW_PERIOD = 128,
    parameter int FAST_PERIOD = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  acpu_io_pkg::item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output acpu_io_pkg::result_t result
);
    import acpu_io_pkg::*;

    localparam int SLOW_W = (SLOW_PERIOD > 1) ? $clog2(SLOW_PERIOD) : 1;
    localparam int FAST_W = (FAST_PERIOD > 1) ? $clog2(FAST_PERIOD) : 1;
    localparam logic [SLOW_W-1:0] SLOW_LAST = SLOW_W'(SLOW_PERIOD - 1);
    localparam logic [FAST_W-1:0] FAST_LAST = FAST_W'(FAST_PERIOD - 1);
    localparam logic [SLOW_W-1:0] SLOW_ONE  = SLOW_W'(1);
    localparam logic [FAST_W-1:0] FAST_ONE  = FAST_W'(1);

    // Architectural state
    logic [SLOW_W-1:0] slow_phase_reg, slow_phase_next;
    logic [FAST_W-1:0] fast_phase_reg, fast_phase_next;
    logic [2:0]        enable_reg, enable_next;
    logic [7:0]        count_reg [3];
    logic [7:0]        count_next [3];
    logic [8:0]        div_reg [3];
    logic [8:0]        div_next [3];
    logic [15:0]       prescale_reg [3];
    logic [15:0]       prescale_next [3];
    logic [7:0]        to_copro_reg [4];
    logic [7:0]        to_copro_next [4];
    logic [7:0]        to_cpu_reg [4];
    logic [7:0]        to_cpu_next [4];
    logic [7:0]        aux_reg [2];
    logic [7:0]        aux_next [2];
    logic              rom_on_reg, rom_on_next;

    // Output stage
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    logic    item_take;
    logic    out_take;
    logic    is_reg;
    logic    slow_hit;
    logic    fast_hit;
    logic    step [3];
    logic [15:0] ps_inc [3];
    result_t res;

    assign item_stall   = skid_valid_reg;
    assign item_take    = item_valid && !skid_valid_reg;
    assign out_take     = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign is_reg   = (item.addr & REG_PAGE_MASK) == REG_PAGE;
    assign slow_hit = slow_phase_reg == '0;
    assign fast_hit = fast_phase_reg == '0;

    // Item processing: state update and result
    always_comb
    begin
        slow_phase_next = slow_phase_reg;
        fast_phase_next = fast_phase_reg;
        enable_next     = enable_reg;
        count_next      = count_reg;
        div_next        = div_reg;
        prescale_next   = prescale_reg;
        to_copro_next   = to_copro_reg;
        to_cpu_next     = to_cpu_reg;
        aux_next        = aux_reg;
        rom_on_next     = rom_on_reg;
        res             = '0;

        for (int t = 0; t < 3; t++)
        begin
            step[t]   = enable_reg[t] && ((t == 2) ? fast_hit : slow_hit);
            ps_inc[t] = prescale_reg[t] + 16'd1;
        end

        if (item_take)
        begin
            case (item.func)
                FUNC_TICK:
                begin
                    slow_phase_next = (slow_phase_reg == SLOW_LAST) ? '0
                                                                    : slow_phase_reg + SLOW_ONE;
                    fast_phase_next = (fast_phase_reg == FAST_LAST) ? '0
                                                                    : fast_phase_reg + FAST_ONE;
                    for (int t = 0; t < 3; t++)
                    begin
                        if (step[t])
                        begin
                            if (ps_inc[t] == {7'd0, div_reg[t]})
                            begin
                                count_next[t]    = count_reg[t] + 8'd1;
                                prescale_next[t] = '0;
                            end
                            else
                            begin
                                prescale_next[t] = ps_inc[t];
                            end
                        end
                    end
                end
                FUNC_COPRO_RD:
                begin
                    if (is_reg)
                    begin
                        res.source = SRC_BLOCK;
                        case (item.addr[3:0])
                            REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
                                res.rdata = to_copro_reg[item.addr[1:0]];
                            REG_AUX0, REG_AUX1:
                                res.rdata = aux_reg[item.addr[0]];
                            REG_DIV0: res.rdata = div_reg[0][7:0];
                            REG_DIV1: res.rdata = div_reg[1][7:0];
                            REG_DIV2: res.rdata = div_reg[2][7:0];
                            REG_CNT0:
                            begin
                                res.rdata     = {4'd0, count_reg[0][3:0]};
                                count_next[0] = '0;
                            end
                            REG_CNT1:
                            begin
                                res.rdata     = {4'd0, count_reg[1][3:0]};
                                count_next[1] = '0;
                            end
                            REG_CNT2:
                            begin
                                res.rdata     = {4'd0, count_reg[2][3:0]};
                                count_next[2] = '0;
                            end
                            default: res.rdata = '0;
                        endcase
                    end
                    else if (rom_on_reg && ((item.addr & ROM_MASK) == ROM_MASK))
                    begin
                        res.source = SRC_ROM;
                    end
                    else
                    begin
                        res.source = SRC_RAM;
                    end
                end
                FUNC_COPRO_WR:
                begin
                    res.ram_store = 1'b1;
                    if (is_reg)
                    begin
                        case (item.addr[3:0])
                            REG_CONTROL:
                            begin
                                for (int t = 0; t < 3; t++)
                                begin
                                    enable_next[t] = item.wdata[t];
                                    if (!item.wdata[t])
                                    begin
                                        count_next[t] = '0;
                                        div_next[t]   = 9'd1;
                                    end
                                end
                                rom_on_next = item.wdata[CTRL_ROM_BIT];
                            end
                            REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
                                to_cpu_next[item.addr[1:0]] = item.wdata;
                            REG_AUX0, REG_AUX1:
                                aux_next[item.addr[0]] = item.wdata;
                            REG_DIV0:
                                div_next[0] = (item.wdata == '0) ? DIV_FULL
                                                                 : {1'b0, item.wdata};
                            REG_DIV1:
                                div_next[1] = (item.wdata == '0) ? DIV_FULL
                                                                 : {1'b0, item.wdata};
                            REG_DIV2:
                                div_next[2] = (item.wdata == '0) ? DIV_FULL
                                                                 : {1'b0, item.wdata};
                            default: ;
                        endcase
                    end
                end
                FUNC_CPU_RD:
                    res.rdata = to_cpu_reg[item.port];
                FUNC_CPU_WR:
                    to_copro_next[item.port] = item.wdata;
                default: ;
            endcase
        end
    end

    // Output stage: result register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (item_take)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_phase_reg <= '0;
            fast_phase_reg <= '0;
            enable_reg     <= '0;
            rom_on_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int t = 0; t < 3; t++)
            begin
                count_reg[t]    <= '0;
                div_reg[t]      <= 9'd1;
                prescale_reg[t] <= '0;
            end
            for (int p = 0; p < 4; p++)
            begin
                to_copro_reg[p] <= '0;
                to_cpu_reg[p]   <= '0;
            end
            for (int a = 0; a < 2; a++)
            begin
                aux_reg[a] <= '0;
            end
        end
        else
        begin
            slow_phase_reg <= slow_phase_next;
            fast_phase_reg <= fast_phase_next;
            enable_reg     <= enable_next;
            rom_on_reg     <= rom_on_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            count_reg      <= count_next;
            div_reg        <= div_next;
            prescale_reg   <= prescale_next;
            to_copro_reg   <= to_copro_next;
            to_cpu_reg     <= to_cpu_next;
            aux_reg        <= aux_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule
